### rtl/hsbc_pkg.sv
// Shared types and constants for the HSB to RGBA converter.
// Used by the stream interfaces and by the converter top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsbc_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned ColorW = 32;

  // Doubled hue thresholds: hue/60deg equals 2*hue/85.
  localparam logic [8:0] HalfSector   = 9'd85;
  localparam logic [8:0] TwoSectors   = 9'd170;
  localparam logic [8:0] ThreeSectors = 9'd255;
  localparam logic [8:0] FourSectors  = 9'd340;
  localparam logic [8:0] FiveSectors  = 9'd425;
  localparam logic [8:0] FullTurn     = 9'd510;

  // Zero channel: floor((n + 127) / 255) through a 257/65536 reciprocal.
  localparam logic [15:0] ZeroBias  = 16'd127;
  localparam logic [23:0] ZeroRecip = 24'd257;
  localparam logic [15:0] Full      = 16'd255;

  // Secondary channel: floor((2N + 21675) / 43350) through a 2^-32 reciprocal.
  localparam logic [22:0] SecScale = 23'd85;
  localparam logic [23:0] SecBias  = 24'd21675;
  localparam logic [23:0] SecDiv   = 24'd43350;
  localparam logic [40:0] SecRecip = 41'd99076;

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_e;

endpackage

`default_nettype wire

### rtl/hsbc_stream_if.sv
// Valid/ready stream interfaces for the HSB input words and RGBA output words.
// Depends on hsbc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hsbc_hsb_if;
  logic                        valid;
  logic                        ready;
  logic [hsbc_pkg::ChanW-1:0]  hue;
  logic [hsbc_pkg::ChanW-1:0]  saturation;
  logic [hsbc_pkg::ChanW-1:0]  brightness;
  logic [hsbc_pkg::ChanW-1:0]  alpha;

  modport source (output valid, hue, saturation, brightness, alpha, input ready);
  modport sink   (input valid, hue, saturation, brightness, alpha, output ready);
endinterface

interface hsbc_rgba_if;
  logic                        valid;
  logic                        ready;
  logic [hsbc_pkg::ColorW-1:0] packed_color;

  modport source (output valid, packed_color, input ready);
  modport sink   (input valid, packed_color, output ready);
endinterface

`default_nettype wire

### rtl/hsb_to_rgba_converter.sv
// HSB to RGBA8888 converter top level: a four-stage valid/ready pipeline.
// Depends on hsbc_pkg and the stream interfaces in hsbc_stream_if.sv.
//
// Usage: each word on hsb_i carries 8-bit hue (0..255 over a full turn),
// saturation, brightness and alpha. Each accepted word yields exactly one
// word on rgba_o, packed as red, green, blue, alpha from the top byte down.
// The conversion is exact fixed point: the largest channel is the
// brightness, the smallest is brightness times (1 - saturation) rounded half
// up, and the remaining channel is found by constant reciprocal multiplies
// with a one-step correction.
// A word accepted from hsb_i passes through the four register stages in turn
// before it is presented on rgba_o. The block accepts one word every cycle
// while the receiver keeps taking words, because each register stage moves on
// as soon as the stage after it does.
// Each stage has its own valid bit and advances whenever it is empty or the
// stage after it moves, so when the receiver stalls the pipeline keeps
// filling its bubbles and only then pushes back on hsb_i. No word is lost
// or repeated during a stall.
// Reset clears all valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module hsb_to_rgba_converter (
  input  wire         clk_i,
  input  wire         rst_ni,
  hsbc_hsb_if.sink    hsb_i,
  hsbc_rgba_if.source rgba_o
);

  // Pipeline control: stage k moves when it is empty or its successor moves.
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, eno;

  assign eno = !vo_q || rgba_o.ready;
  assign en3 = !v3_q || eno;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign hsb_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= hsb_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  // Stage 1: hue sector and secondary weight f = 85 - |(2h mod 170) - 85|,
  // plus the two brightness products b*s and b*(255-s).
  logic [8:0]  hue2;
  logic [8:0]  rem2;
  logic [6:0]  hue_gap;
  logic [6:0]  f_d;
  logic [2:0]  sec_cnt;
  logic [15:0] bs_d, n_d;

  always_comb begin
    hue2 = {hsb_i.hue, 1'b0};
    priority if (hue2 >= hsbc_pkg::FullTurn)    rem2 = hue2 - hsbc_pkg::FullTurn;
    else if (hue2 >= hsbc_pkg::FourSectors)     rem2 = hue2 - hsbc_pkg::FourSectors;
    else if (hue2 >= hsbc_pkg::TwoSectors)      rem2 = hue2 - hsbc_pkg::TwoSectors;
    else                                        rem2 = hue2;
    if (rem2 >= hsbc_pkg::HalfSector) hue_gap = 7'(rem2 - hsbc_pkg::HalfSector);
    else                              hue_gap = 7'(hsbc_pkg::HalfSector - rem2);
    f_d = 7'(hsbc_pkg::HalfSector) - hue_gap;
    // Counting only five thresholds folds hue 255 into the last sector.
    sec_cnt = {2'b0, hue2 >= hsbc_pkg::HalfSector}
            + {2'b0, hue2 >= hsbc_pkg::TwoSectors}
            + {2'b0, hue2 >= hsbc_pkg::ThreeSectors}
            + {2'b0, hue2 >= hsbc_pkg::FourSectors}
            + {2'b0, hue2 >= hsbc_pkg::FiveSectors};
    bs_d = 16'(hsb_i.brightness) * 16'(hsb_i.saturation);
    n_d  = 16'(hsb_i.brightness) * {8'b0, ~hsb_i.saturation};
  end

  hsbc_pkg::sector_e sec1_q, sec2_q, sec3_q;
  logic [6:0]  f1_q;
  logic [15:0] bs1_q, n1_q;
  logic [7:0]  b1_q, b2_q, b3_q;
  logic [7:0]  a1_q, a2_q, a3_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sec1_q <= hsbc_pkg::sector_e'(sec_cnt);
      f1_q   <= f_d;
      bs1_q  <= bs_d;
      n1_q   <= n_d;
      b1_q   <= hsb_i.brightness;
      a1_q   <= hsb_i.alpha;
    end
  end

  // Stage 2: secondary numerator terms and the zero-channel estimate.
  logic [22:0] t_d, u_d;
  logic [15:0] y_d;
  logic [23:0] zp;

  always_comb begin
    t_d = 23'(bs1_q) * 23'(f1_q);
    u_d = 23'(n1_q) * hsbc_pkg::SecScale;
    y_d = n1_q + hsbc_pkg::ZeroBias;
    zp  = 24'(y_d) * hsbc_pkg::ZeroRecip;
  end

  logic [22:0] t2_q, u2_q;
  logic [15:0] y2_q;
  logic [7:0]  zq2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      t2_q   <= t_d;
      u2_q   <= u_d;
      y2_q   <= y_d;
      zq2_q  <= zp[23:16];
      sec2_q <= sec1_q;
      b2_q   <= b1_q;
      a2_q   <= a1_q;
    end
  end

  // Stage 3: secondary estimate by reciprocal and zero-channel correction.
  logic [22:0] nsum;
  logic [23:0] x_d;
  logic [40:0] sp;
  logic [15:0] zr;
  logic [7:0]  zer_d;

  always_comb begin
    nsum  = t2_q + u2_q;
    x_d   = {nsum, 1'b0} + hsbc_pkg::SecBias;
    sp    = 41'(x_d) * hsbc_pkg::SecRecip;
    zr    = y2_q - 16'(zq2_q) * hsbc_pkg::Full;
    zer_d = zq2_q + {7'b0, zr >= hsbc_pkg::Full};
  end

  logic [23:0] x3_q;
  logic [7:0]  sq3_q, zer3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      x3_q   <= x_d;
      sq3_q  <= sp[39:32];
      zer3_q <= zer_d;
      sec3_q <= sec2_q;
      b3_q   <= b2_q;
      a3_q   <= a2_q;
    end
  end

  // Output stage: secondary correction, channel routing by sector, packing.
  logic [23:0] sr;
  logic [7:0]  sec_val;
  logic [7:0]  red, grn, blu;

  always_comb begin
    sr      = x3_q - 24'(sq3_q) * hsbc_pkg::SecDiv;
    sec_val = sq3_q + {7'b0, sr >= hsbc_pkg::SecDiv};
    unique case (sec3_q)
      hsbc_pkg::SEC_RED_YEL: begin red = b3_q;    grn = sec_val; blu = zer3_q;  end
      hsbc_pkg::SEC_YEL_GRN: begin red = sec_val; grn = b3_q;    blu = zer3_q;  end
      hsbc_pkg::SEC_GRN_CYN: begin red = zer3_q;  grn = b3_q;    blu = sec_val; end
      hsbc_pkg::SEC_CYN_BLU: begin red = zer3_q;  grn = sec_val; blu = b3_q;    end
      hsbc_pkg::SEC_BLU_MAG: begin red = sec_val; grn = zer3_q;  blu = b3_q;    end
      default:               begin red = b3_q;    grn = zer3_q;  blu = sec_val; end
    endcase
  end

  logic [31:0] color_q;

  always_ff @(posedge clk_i) begin
    if (eno) color_q <= {red, grn, blu, a3_q};
  end

  assign rgba_o.valid        = vo_q;
  assign rgba_o.packed_color = color_q;

  // An accepted word always lands in the first stage.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsb_i.valid && hsb_i.ready) |=> v1_q)
    else $error("accepted word not captured in stage 1");

  // The reciprocal estimate of the secondary channel is off by at most one.
  a_sec_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (sr < 24'd86700))
    else $error("secondary reciprocal estimate out of range");

  // The secondary channel lies between the zero channel and the brightness.
  a_sec_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (sec_val <= b3_q && sec_val >= zer3_q))
    else $error("secondary channel outside zero..brightness");

  // A stalled output word stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vo_q && !rgba_o.ready) |=> (vo_q && $stable(color_q)))
    else $error("output word changed while stalled");

endmodule

`default_nettype wire

### test/hsb_to_rgba_converter_test.sv
// Self-checking testbench for the HSB to RGBA converter pipeline.
// Depends on hsbc_pkg, the stream interfaces in hsbc_stream_if.sv and the converter RTL.
`timescale 1ns / 1ps

module hsb_to_rgba_converter_test;

  // One HSB word as it travels on the input stream.
  typedef struct packed {
    logic [hsbc_pkg::ChanW-1:0] hue;
    logic [hsbc_pkg::ChanW-1:0] saturation;
    logic [hsbc_pkg::ChanW-1:0] brightness;
    logic [hsbc_pkg::ChanW-1:0] alpha;
  } hsb_word_t;

  // One RGBA word, laid out exactly as the packed output color.
  typedef struct packed {
    logic [hsbc_pkg::ChanW-1:0] red;
    logic [hsbc_pkg::ChanW-1:0] green;
    logic [hsbc_pkg::ChanW-1:0] blue;
    logic [hsbc_pkg::ChanW-1:0] alpha;
  } rgba_word_t;

  // A color that is still owed by the converter, kept with the pixel that
  // caused it so that a mismatch report can show the input too.
  typedef struct {
    hsb_word_t  pixel;
    rgba_word_t color;
  } pending_color_t;

  typedef enum logic {
    SINK_ALWAYS,
    SINK_PATTERN
  } sink_mode_e;

  // The hue circle is worked in doubled hue units: one 60 degree sector is
  // 85 units wide, so a full turn of 0..255 hue steps covers 510 units.
  localparam int unsigned SectorSpan = 85;
  localparam int unsigned ChanMax    = 255;
  localparam int unsigned LastSector = 5;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned DrainCycles  = 10;
  localparam int unsigned HoldOffSpan  = 400;
  localparam int unsigned ReportedMax  = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  hsbc_hsb_if  hsb_if ();
  hsbc_rgba_if rgba_if ();

  hsb_to_rgba_converter i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .hsb_i  (hsb_if),
    .rgba_o (rgba_if)
  );

  // 12 ns period, high and low halves of equal length.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pending_color_t pending_colors [$];
  int unsigned    mismatch_count = 0;
  int unsigned    stall_cycles   = 0;
  int unsigned    hold_off_len   = 0;
  sink_mode_e     sink_mode      = SINK_ALWAYS;

  // Converts one HSB word to its RGBA word. The largest channel is the
  // brightness itself, the smallest is brightness * (1 - saturation) rounded
  // half up, and the remaining one sits in between, scaled by how far the hue
  // lies from the nearest pure red, green or blue. All divisions are exact
  // integer divisions, so rounding is half up without any float involved.
  function automatic rgba_word_t hsb_to_rgba(hsb_word_t px);
    int unsigned       h, s, b;
    int unsigned       sector_idx, turn_pos, edge_dist, ramp;
    int unsigned       ramp_num, ramp_chan, floor_chan;
    hsbc_pkg::sector_e sector;
    rgba_word_t        color;
    h = px.hue;
    s = px.saturation;
    b = px.brightness;
    // Hue 255 is a full turn and lands one sector past the last; it is
    // folded back into the magenta-red sector, where its ramp is zero.
    sector_idx = (2 * h) / SectorSpan;
    if (sector_idx > LastSector) begin
      sector_idx = LastSector;
    end
    sector = hsbc_pkg::sector_e'(3'(sector_idx));
    turn_pos  = (2 * h) % (2 * SectorSpan);
    edge_dist = (turn_pos >= SectorSpan) ? turn_pos - SectorSpan : SectorSpan - turn_pos;
    ramp      = SectorSpan - edge_dist;
    ramp_num  = b * s * ramp + SectorSpan * b * (ChanMax - s);
    ramp_chan = (2 * ramp_num + SectorSpan * ChanMax) / (2 * SectorSpan * ChanMax);
    floor_chan = (2 * b * (ChanMax - s) + ChanMax) / (2 * ChanMax);
    case (sector)
      hsbc_pkg::SEC_RED_YEL: begin
        color.red = b[7:0];          color.green = ramp_chan[7:0]; color.blue = floor_chan[7:0];
      end
      hsbc_pkg::SEC_YEL_GRN: begin
        color.red = ramp_chan[7:0];  color.green = b[7:0];         color.blue = floor_chan[7:0];
      end
      hsbc_pkg::SEC_GRN_CYN: begin
        color.red = floor_chan[7:0]; color.green = b[7:0];         color.blue = ramp_chan[7:0];
      end
      hsbc_pkg::SEC_CYN_BLU: begin
        color.red = floor_chan[7:0]; color.green = ramp_chan[7:0]; color.blue = b[7:0];
      end
      hsbc_pkg::SEC_BLU_MAG: begin
        color.red = ramp_chan[7:0];  color.green = floor_chan[7:0]; color.blue = b[7:0];
      end
      default: begin
        color.red = b[7:0];          color.green = floor_chan[7:0]; color.blue = ramp_chan[7:0];
      end
    endcase
    color.alpha = px.alpha;
    return color;
  endfunction

  // Offers one word on the input stream and returns at the edge where it is
  // taken. valid stays high on return, so back-to-back calls give a word
  // every cycle while the converter is ready; only pause_sender lowers it.
  task automatic send_pixel(input logic [hsbc_pkg::ChanW-1:0] hue,
                            input logic [hsbc_pkg::ChanW-1:0] sat,
                            input logic [hsbc_pkg::ChanW-1:0] bri,
                            input logic [hsbc_pkg::ChanW-1:0] alp);
    hsb_word_t      px;
    pending_color_t owed;
    px = {hue, sat, bri, alp};
    hsb_if.valid      <= 1'b1;
    hsb_if.hue        <= px.hue;
    hsb_if.saturation <= px.saturation;
    hsb_if.brightness <= px.brightness;
    hsb_if.alpha      <= px.alpha;
    do begin
      @(posedge clk);
    end while (hsb_if.ready !== 1'b1);
    owed.pixel = px;
    owed.color = hsb_to_rgba(px);
    pending_colors.push_back(owed);
  endtask

  // Drops valid for a number of cycles. The payload is scrambled meanwhile,
  // since the converter must ignore it while valid is low.
  task automatic pause_sender(input int unsigned cycles);
    if (cycles > 0) begin
      hsb_if.valid      <= 1'b0;
      hsb_if.hue        <= 8'($urandom);
      hsb_if.saturation <= 8'($urandom);
      hsb_if.brightness <= 8'($urandom);
      hsb_if.alpha      <= 8'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Saturation, brightness and alpha lean toward their end values, where
  // the zero channel and the ramp channel collapse.
  function automatic logic [hsbc_pkg::ChanW-1:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return 8'($urandom_range(0, ChanMax));
    endcase
  endfunction

  // Hue leans toward the sector edges, the hue just past them and the full
  // turn, since that is where sector selection can go wrong.
  function automatic logic [hsbc_pkg::ChanW-1:0] pick_hue();
    logic [hsbc_pkg::ChanW-1:0] sector_edges [13];
    sector_edges = '{8'd0, 8'd42, 8'd43, 8'd84, 8'd85, 8'd127, 8'd128,
                     8'd169, 8'd170, 8'd212, 8'd213, 8'd254, 8'd255};
    if ($urandom_range(0, 4) == 0) begin
      return sector_edges[$urandom_range(0, 12)];
    end
    return 8'($urandom_range(0, ChanMax));
  endfunction

  // Sends a stream of random words in bursts of random length. With gaps
  // off the stream is continuous; with gaps on, valid drops for a random
  // number of cycles (sometimes none) after each burst.
  task automatic send_random_stream(input int unsigned count, input bit with_gaps);
    int unsigned sent;
    int unsigned burst_len;
    sent = 0;
    while (sent < count) begin
      burst_len = $urandom_range(1, 16);
      for (int unsigned i = 0; i < burst_len && sent < count; i++) begin
        send_pixel(pick_hue(), pick_level(), pick_level(), pick_level());
        sent++;
      end
      if (with_gaps) begin
        pause_sender($urandom_range(0, 7));
      end
    end
  endtask

  // Directed corners: every sector edge at full color, the full-turn hue,
  // gray (no saturation), black (no brightness), all-zero and all-one words,
  // and alpha patterns that toggle every bit of the low byte.
  task automatic test_directed_corners();
    sink_mode = SINK_ALWAYS;
    send_pixel(8'd0,   8'd255, 8'd255, 8'd255);
    send_pixel(8'd42,  8'd255, 8'd255, 8'd0);
    send_pixel(8'd43,  8'd255, 8'd255, 8'd255);
    send_pixel(8'd84,  8'd255, 8'd255, 8'd1);
    send_pixel(8'd85,  8'd255, 8'd255, 8'd128);
    send_pixel(8'd127, 8'd255, 8'd255, 8'd254);
    send_pixel(8'd128, 8'd255, 8'd255, 8'd127);
    send_pixel(8'd170, 8'd255, 8'd255, 8'd85);
    send_pixel(8'd212, 8'd255, 8'd255, 8'd170);
    send_pixel(8'd213, 8'd255, 8'd255, 8'd15);
    send_pixel(8'd254, 8'd255, 8'd255, 8'd240);
    // Full turn: must come out identical to hue 0 in color.
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd128, 8'd200, 8'd0);
    // Gray: without saturation all three channels equal the brightness.
    send_pixel(8'd100, 8'd0,   8'd200, 8'd85);
    // Black: without brightness hue and saturation do not matter.
    send_pixel(8'd60,  8'd255, 8'd0,   8'd170);
    send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd30,  8'd1,   8'd1,   8'd128);
    send_pixel(8'd21,  8'd170, 8'd85,  8'd127);
    send_pixel(8'd200, 8'd85,  8'd170, 8'd254);
    send_pixel(8'd150, 8'd127, 8'd128, 8'd1);
    pause_sender(1);
  endtask

  // A word every cycle in and out, without idling on either side.
  task automatic test_full_rate_stream();
    sink_mode = SINK_ALWAYS;
    send_random_stream(400, 1'b0);
  endtask

  // Sender bursts against a receiver that stalls on its own pattern, so
  // bubbles and stalls land on every pipeline stage.
  task automatic test_bursty_traffic();
    sink_mode = SINK_PATTERN;
    send_random_stream(900, 1'b1);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering words: the pipeline fills up and must push back on its input
  // without losing or repeating a word.
  task automatic test_output_hold_off();
    sink_mode    = SINK_ALWAYS;
    hold_off_len = HoldOffSpan;
    send_random_stream(60, 1'b0);
  endtask

  task automatic test_mixed_traffic();
    sink_mode = SINK_PATTERN;
    send_random_stream(370, 1'b1);
    pause_sender(1);
  endtask

  // Waits until every owed color has come back, then a few more cycles so
  // that a stray extra word would still be caught, and gives the verdict.
  task automatic finish_run();
    sink_mode = SINK_ALWAYS;
    while (pending_colors.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_colors.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  endtask

  // Stimulus: reset once, then the tests in turn.
  initial begin
    hsb_if.valid      = 1'b0;
    hsb_if.hue        = '0;
    hsb_if.saturation = '0;
    hsb_if.brightness = '0;
    hsb_if.alpha      = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_full_rate_stream();
    test_bursty_traffic();
    test_output_hold_off();
    test_mixed_traffic();
    finish_run();
  end

  // Receiver: always ready, or alternating ready runs and stalls of random
  // length. A requested hold-off is counted out here, in cycles. Every pass
  // through the loop waits on the clock before it goes round again, so ready
  // never gets two assignments in the same step.
  initial begin
    int unsigned run_len;
    rgba_if.ready = 1'b0;
    forever begin
      if (hold_off_len != 0) begin
        rgba_if.ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
      end else if (sink_mode == SINK_ALWAYS) begin
        rgba_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        run_len = $urandom_range(1, 6);
        rgba_if.ready <= 1'b1;
        repeat (run_len) @(posedge clk);
        run_len = $urandom_range(0, 4);
        if (run_len != 0) begin
          rgba_if.ready <= 1'b0;
          repeat (run_len) @(posedge clk);
        end
      end
    end
  end

  // Checker: each word taken from the output is compared channel by channel
  // with the oldest owed color. Values are sampled at the edge, before any
  // register or driven input changes in that step.
  always @(posedge clk) begin
    pending_color_t owed;
    rgba_word_t     got;
    if (rst_n && rgba_if.valid === 1'b1 && rgba_if.ready === 1'b1) begin
      got = rgba_if.packed_color;
      if (pending_colors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportedMax) begin
          $display("Unexpected output word %08h with no color owed", got);
        end
      end else begin
        owed = pending_colors.pop_front();
        if (got.red !== owed.color.red || got.green !== owed.color.green ||
            got.blue !== owed.color.blue || got.alpha !== owed.color.alpha) begin
          mismatch_count++;
          if (mismatch_count <= ReportedMax) begin
            $display("Mismatch for h=%0d s=%0d b=%0d a=%0d: expected %08h, got %08h",
                     owed.pixel.hue, owed.pixel.saturation, owed.pixel.brightness,
                     owed.pixel.alpha, owed.color, got);
          end
        end
      end
    end
  end

  // Watchdog: ends the run if no word moves on either stream for too long.
  // The longest legitimate quiet stretch is the receiver hold-off.
  always @(posedge clk) begin
    if ((hsb_if.valid === 1'b1 && hsb_if.ready === 1'b1) ||
        (rgba_if.valid === 1'b1 && rgba_if.ready === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Timeout: no word moved for %0d cycles", stall_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule

### sim.f
rtl/hsbc_pkg.sv
rtl/hsbc_stream_if.sv
rtl/hsb_to_rgba_converter.sv
test/hsb_to_rgba_converter_test.sv
